/* design/sli_pkg.sv */
// ----------------------------------------------------------------------------
// sli_pkg
// shared types and codes for the sorted list block: request and response
// payloads, cell control and neighbour links, state machine states
// ----------------------------------------------------------------------------
package sli_pkg;

   // request kinds
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   // response status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_EMPTY     = 3'd3;
   localparam logic [2:0] ST_BAD_INDEX = 3'd4;

   // number of positions reachable by the read index
   localparam int unsigned READ_SPAN = 16;

   typedef struct packed {
      logic [1:0]          req_type;
      logic signed [31:0]  value;
      logic [3:0]          index;
   } req_item_type;

   typedef struct packed {
      logic [2:0]          status;
      logic signed [31:0]  read_value;
      logic [4:0]          entry_count;
   } rsp_item_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_CMP,
      CELL_INSERT,
      CELL_REMOVE
   } cell_cmd_type;

   // broadcast to every cell
   typedef struct packed {
      cell_cmd_type        cmd;
      logic signed [31:0]  key;
   } cell_ctl_type;

   // what one cell shows its neighbours
   typedef struct packed {
      logic signed [31:0]  data;
      logic                valid;
      logic                keep;
   } cell_link_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_CMP,
      FSM_APPLY
   } fsm_state_type;

endpackage

/* design/sli_cell.sv */
// ----------------------------------------------------------------------------
// sli_cell
// one position of the sorted list: holds an entry and its valid bit, compares
// against the request key and shifts towards either neighbour
// ----------------------------------------------------------------------------
module sli_cell
   import sli_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctl_type  ctl,
   input  cell_link_type left_link,
   input  cell_link_type right_link,
   output cell_link_type self_link,
   output logic          hit
);

   logic signed [31:0] data_ff, data_in;
   logic               valid_ff, valid_in;
   logic               keep_ff, keep_in;
   logic               eq_ff, eq_in;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      keep_in  = keep_ff;
      eq_in    = eq_ff;
      unique case (ctl.cmd)
         CELL_CMP: begin
            // keep: entry lies strictly below the key, so it stays put
            keep_in = valid_ff && ($signed(data_ff) < $signed(ctl.key));
            eq_in   = (data_ff == ctl.key);
         end
         CELL_INSERT: begin
            if (!keep_ff) begin
               if (left_link.keep) begin
                  data_in  = ctl.key;
                  valid_in = 1'b1;
               end else begin
                  data_in  = left_link.data;
                  valid_in = left_link.valid;
               end
            end
         end
         CELL_REMOVE: begin
            if (!keep_ff) begin
               data_in  = right_link.data;
               valid_in = right_link.valid;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         keep_ff  <= 1'b0;
         eq_ff    <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         keep_ff  <= keep_in;
         eq_ff    <= eq_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // first entry not below the key, and equal to it
   assign hit = valid_ff && eq_ff && !keep_ff && left_link.keep;

   assign self_link.data  = data_ff;
   assign self_link.valid = valid_ff;
   assign self_link.keep  = keep_ff;

endmodule

/* design/sorted_list_insert_remove.sv */
// ----------------------------------------------------------------------------
// sorted_list_insert_remove
// bounded list of signed 32-bit values kept in ascending order, held in a row
// of compare-and-shift cells; insert, remove-first-equal and read by index
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_item  (req_type, value, index)
//   rsp      out        rsp_valid/rsp_ready  rsp_item  (status, read_value,
//                                                       entry_count)
//
// each request goes through capture, compare in every cell, then
// shift/apply; the next request is taken in the cycle after apply
// the apply step waits while the previous response transfer is still pending,
// a new request is taken while a response waits
// reset clears the valid bit of every cell and the entry count; entry data
// is not reset and is never shown unless valid
//
module sorted_list_insert_remove
   import sli_pkg::*;
#(
   parameter int unsigned CAPACITY = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   localparam int unsigned CW = $clog2(CAPACITY + 1);

   // control registers
   fsm_state_type   state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // payload registers
   req_item_type    req_ff, req_in;
   rsp_item_type    rsp_ff, rsp_in;

   // cell row
   cell_ctl_type    ctl;
   cell_link_type   links [CAPACITY];
   logic [CAPACITY-1:0] hits;
   cell_link_type   head_link;
   cell_link_type   tail_link;

   // read port over the first positions
   logic signed [31:0]    rd_vals [READ_SPAN];
   logic [READ_SPAN-1:0]  rd_ok;

   logic req_fire;
   logic apply_fire;
   logic found;
   logic list_empty;
   logic list_full;
   logic idx_in_range;

   // the head behaves as an entry below everything, the tail as empty space
   assign head_link.data  = '0;
   assign head_link.valid = 1'b1;
   assign head_link.keep  = 1'b1;
   assign tail_link.data  = '0;
   assign tail_link.valid = 1'b0;
   assign tail_link.keep  = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      cell_link_type left_l, right_l;
      if (i == 0) begin : g_first
         assign left_l = head_link;
      end else begin : g_mid_l
         assign left_l = links[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_l = tail_link;
      end else begin : g_mid_r
         assign right_l = links[i+1];
      end
      sli_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .left_link  (left_l),
         .right_link (right_l),
         .self_link  (links[i]),
         .hit        (hits[i])
      );
   end

   for (genvar r = 0; r < READ_SPAN; r++) begin : g_rd
      if (r < CAPACITY) begin : g_on
         assign rd_vals[r] = links[r].data;
         assign rd_ok[r]   = links[r].valid;
      end else begin : g_off
         assign rd_vals[r] = '0;
         assign rd_ok[r]   = 1'b0;
      end
   end

   assign found        = |hits;
   assign list_empty   = !links[0].valid;
   assign list_full    = links[CAPACITY-1].valid;
   assign idx_in_range = (32'(req_ff.index) < 32'(CAPACITY));

   assign req_fire   = req_valid && req_ready;
   assign apply_fire = (state_ff == FSM_APPLY) && (!rsp_valid_ff || rsp_ready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE:  if (req_fire) state_in = FSM_CMP;
         FSM_CMP:   state_in = FSM_APPLY;
         FSM_APPLY: if (apply_fire) state_in = FSM_IDLE;
         default:   state_in = FSM_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_ready    = (state_ff == FSM_IDLE);
      req_in       = req_fire ? req_item : req_ff;
      ctl.key      = req_ff.value;
      ctl.cmd      = CELL_HOLD;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         FSM_CMP: begin
            ctl.cmd = CELL_CMP;
         end
         FSM_APPLY: begin
            if (apply_fire) begin
               rsp_in.status     = ST_OK;
               rsp_in.read_value = '0;
               rsp_valid_in      = 1'b1;
               case (req_ff.req_type)
                  OP_INSERT: begin
                     if (list_full) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        ctl.cmd  = CELL_INSERT;
                        count_in = CW'(count_ff + 1'b1);
                     end
                  end
                  OP_REMOVE: begin
                     if (list_empty) begin
                        rsp_in.status = ST_EMPTY;
                     end else if (!found) begin
                        rsp_in.status = ST_NOT_FOUND;
                     end else begin
                        ctl.cmd  = CELL_REMOVE;
                        count_in = CW'(count_ff - 1'b1);
                     end
                  end
                  OP_READ: begin
                     if (idx_in_range && rd_ok[req_ff.index]) begin
                        rsp_in.read_value = rd_vals[req_ff.index];
                     end else begin
                        rsp_in.status = ST_BAD_INDEX;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_in.entry_count = 5'(count_in);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // checks

   // entry count never exceeds the row length
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count beyond capacity");

   // empty row and zero count agree
   a_empty_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) == !links[0].valid)
      else $error("count and head valid bit disagree");

   // full row and full count agree
   a_full_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CW'(CAPACITY)) == links[CAPACITY-1].valid)
      else $error("count and tail valid bit disagree");

   // compare step is always followed by apply
   a_cmp_then_apply: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_CMP) |=> (state_ff == FSM_APPLY))
      else $error("compare step not followed by apply");

endmodule

/* dv/sorted_list_insert_remove_tb.sv */
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_tb
// self-checking bench for the sorted list block: a directed table covering the
// value extremes, every request kind, full, empty, not-found and bad-index
// cases, then randomised insert/remove/read traffic checked against an
// in-bench model of the ordered list, under varying idle and stall patterns
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_tb;
   import sli_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LIST_DEPTH   = 16;
   localparam int unsigned RESET_CYCLES = 11;
   localparam int unsigned PHASE_ITEMS  = 425;
   localparam int unsigned SETTLE_CYCLES = 20;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned REPORT_LIMIT = 10;

   // request kind with no defined action
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_item_type rsp_item;

   // one line of the directed table; typed rows carry their own expectation
   typedef struct {
      req_item_type req;
      bit           typed;
      rsp_item_type rsp;
   } directed_row_type;

   directed_row_type directed_rows[$];

   // model of the ordered list, updated as each request transfer is accepted
   logic signed [31:0] shadow_list [LIST_DEPTH];
   int unsigned        shadow_count;

   // responses still owed by the block, oldest first
   rsp_item_type pending_rsps[$];

   int unsigned mismatch_count;
   int unsigned cycle_count;

   // idle control, percentages out of a hundred
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int unsigned send_burst;
   int unsigned recv_burst;

   // list growing or shrinking, flips every few dozen random items
   bit grow_bias;

   sorted_list_insert_remove #(
      .CAPACITY (LIST_DEPTH)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run guard: a correct run finishes far below this
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sorted_list_insert_remove_tb failed");
         $finish;
      end
   end

   // apply one request to the model list and work out the response it earns
   task automatic apply_to_shadow_list(input req_item_type r, output rsp_item_type res);
      int unsigned pos;
      res = '0;
      res.status = ST_OK;
      case (r.req_type)
         OP_INSERT: begin
            if (shadow_count >= LIST_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               // new value goes ahead of any equal entries
               pos = 0;
               while (pos < shadow_count && shadow_list[pos] < r.value) pos++;
               for (int i = shadow_count; i > pos; i--) shadow_list[i] = shadow_list[i-1];
               shadow_list[pos] = r.value;
               shadow_count++;
            end
         end
         OP_REMOVE: begin
            if (shadow_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               pos = 0;
               while (pos < shadow_count && shadow_list[pos] != r.value) pos++;
               if (pos >= shadow_count) begin
                  res.status = ST_NOT_FOUND;
               end else begin
                  for (int i = pos; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
                  shadow_count--;
               end
            end
         end
         OP_READ: begin
            if (r.index < shadow_count) begin
               res.read_value = shadow_list[r.index];
            end else begin
               res.status = ST_BAD_INDEX;
            end
         end
         default: begin
            // unused kind: list untouched, plain ok
         end
      endcase
      res.entry_count = shadow_count[4:0];
   endtask

   function automatic void add_row(logic [1:0] op, logic signed [31:0] val, logic [3:0] idx,
                                   bit typed = 1'b0, logic [2:0] st = ST_OK,
                                   logic signed [31:0] rd = '0, logic [4:0] cnt = '0);
      directed_row_type row;
      row.req.req_type = op;
      row.req.value    = val;
      row.req.index    = idx;
      row.typed        = typed;
      row.rsp.status      = st;
      row.rsp.read_value  = rd;
      row.rsp.entry_count = cnt;
      directed_rows.push_back(row);
   endfunction

   // values clustered near zero so duplicates and remove hits are common,
   // with the extremes and fully random patterns mixed in
   function automatic logic signed [31:0] pick_value();
      logic signed [31:0] v;
      case ($urandom_range(9))
         0, 1, 2, 3, 4: v = int'($urandom_range(8)) - 4;
         5: begin
            case ($urandom_range(5))
               0: v = VAL_MIN;
               1: v = VAL_MAX;
               2: v = VAL_MIN + 1;
               3: v = VAL_MAX - 1;
               4: v = 0;
               default: v = -1;
            endcase
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   function automatic req_item_type make_random_request();
      req_item_type r;
      int unsigned  roll;
      r.value = pick_value();
      r.index = 4'($urandom_range(15));
      roll    = $urandom_range(99);
      if (roll < 3) begin
         r.req_type = OP_UNUSED;
      end else if (roll < 20) begin
         r.req_type = OP_READ;
         // mostly a live position, sometimes anywhere in range
         if (shadow_count > 0 && $urandom_range(99) < 75)
            r.index = 4'($urandom_range(shadow_count - 1));
      end else if (roll < (grow_bias ? 70 : 40)) begin
         r.req_type = OP_INSERT;
      end else begin
         r.req_type = OP_REMOVE;
         // usually aim at a stored value so the removal really happens
         if (shadow_count > 0 && $urandom_range(99) < 60)
            r.value = shadow_list[$urandom_range(shadow_count - 1)];
      end
      return r;
   endfunction

   // starts and ends at a falling edge; valid stays high after the transfer so
   // the next call can either hold it up with a new payload or drop it
   task automatic send_request(input req_item_type r, input bit typed,
                               input rsp_item_type typed_rsp);
      rsp_item_type predicted;
      if (send_burst > 0) begin
         send_burst--;
      end else if ($urandom_range(99) < 5) begin
         send_burst = $urandom_range(10, 40);
      end
      while (send_burst == 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= r;
      do @(posedge clock); while (!req_ready);
      // transfer accepted at this edge
      apply_to_shadow_list(r, predicted);
      pending_rsps.push_back(typed ? typed_rsp : predicted);
      @(negedge clock);
   endtask

   // hold the request side off until every owed response has arrived
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // receiver stalls, with occasional stall-free stretches
   always @(negedge clock) begin
      if (recv_burst > 0) begin
         recv_burst--;
      end else if ($urandom_range(99) < 5) begin
         recv_burst = $urandom_range(10, 40);
      end
      rsp_ready <= (recv_burst > 0) || ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic void note_mismatch(string what, longint want, longint got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
   endfunction

   // response check against the oldest owed result
   always @(posedge clock) begin : rsp_check
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsps.size() == 0) begin
            note_mismatch("unexpected response, status", -1, rsp_item.status);
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_item.status !== want.status)
               note_mismatch("status", want.status, rsp_item.status);
            if (rsp_item.read_value !== want.read_value)
               note_mismatch("read_value", want.read_value, rsp_item.read_value);
            if (rsp_item.entry_count !== want.entry_count)
               note_mismatch("entry_count", want.entry_count, rsp_item.entry_count);
         end
      end
   end

   initial begin
      rsp_item_type no_rsp;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_item       = '0;
      rsp_ready      = 1'b0;
      shadow_count   = 0;
      mismatch_count = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_burst     = 0;
      recv_burst     = 0;
      grow_bias      = 1'b1;
      no_rsp         = '0;

      // directed table
      // empty list cases
      add_row(OP_READ,   0, 4'd0, 1'b1, ST_BAD_INDEX, 0, 5'd0);
      add_row(OP_REMOVE, 0, 4'd0, 1'b1, ST_EMPTY,     0, 5'd0);
      // extremes, equal value goes ahead of its twin
      add_row(OP_INSERT, VAL_MAX, 4'd0, 1'b1, ST_OK, 0, 5'd1);
      add_row(OP_INSERT, VAL_MIN, 4'd0, 1'b1, ST_OK, 0, 5'd2);
      add_row(OP_INSERT, 0,       4'd0, 1'b1, ST_OK, 0, 5'd3);
      add_row(OP_INSERT, VAL_MIN, 4'd0, 1'b1, ST_OK, 0, 5'd4);
      add_row(OP_READ,   0,       4'd0, 1'b1, ST_OK, VAL_MIN, 5'd4);
      add_row(OP_READ,   0,       4'd15, 1'b1, ST_BAD_INDEX, 0, 5'd4);
      add_row(OP_REMOVE, 5,       4'd0, 1'b1, ST_NOT_FOUND, 0, 5'd4);
      add_row(OP_REMOVE, VAL_MAX, 4'd0, 1'b1, ST_OK, 0, 5'd3);
      add_row(OP_UNUSED, -1,      4'd9, 1'b1, ST_OK, 0, 5'd3);
      // fill to capacity with alternating bit patterns
      for (int k = 4; k <= LIST_DEPTH; k++)
         add_row(OP_INSERT, (k % 2) ? 32'sh5555_5555 - k : -32'sh2AAA_AAAB + k, 4'd0,
                 1'b1, ST_OK, 0, k[4:0]);
      add_row(OP_INSERT, 7, 4'd0, 1'b1, ST_FULL, 0, 5'd16);
      // reads of a full list, checked by the model
      add_row(OP_READ, 0, 4'd15);
      add_row(OP_READ, 0, 4'd6);

      // synchronous reset, released at a falling edge
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
      drain_responses();

      // random phases: no idling, sender idle, receiver stall, both
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 50 == 0) grow_bias = ~grow_bias;
            send_request(make_random_request(), 1'b0, no_rsp);
         end
         // full drain between phases
         drain_responses();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_rsps.size() == 0) begin
         $display("sorted_list_insert_remove_tb passed");
      end else begin
         $display("sorted_list_insert_remove_tb failed");
      end
      $finish;
   end

endmodule
